[rtl/core/cbp_pkg.sv]
// ----------------------------------------------------------------------------
// cbp_pkg
// types, widths and constants shared by the camera box push-out blocks
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;
  localparam int EW        = 31;
  localparam int DW        = CW + 2;
  localparam int NW        = 31;
  localparam int SHW       = $clog2(DW);
  localparam int RW        = 64;
  localparam int LW        = RW / 2;
  localparam int SRW       = LW + 4;
  localparam int QVW       = FRAC_BITS + 1;
  localparam int VRW       = LW + 1;
  localparam int PNW       = DW + FRAC_BITS;
  localparam int PRW       = QVW + 1;
  localparam int TW        = PNW + 1;
  localparam int MW        = (TW + QVW > 63) ? TW + QVW : 63;
  localparam int AW        = 66;

  localparam int FQ_DEPTH  = 4;
  localparam int FQ_AW     = $clog2(FQ_DEPTH);
  localparam int FQ_CW     = FQ_AW + 1;

  localparam logic [EW-1:0] MARGIN_RESET = EW'((2 ** FRAC_BITS) / 5);
  localparam logic [MW-1:0] SAT_LIM      = MW'(1) << 62;

  typedef struct packed {
    logic signed [CW-1:0] box_corner_x;
    logic signed [CW-1:0] box_corner_z;
    logic [EW-1:0]        edge_size;
    logic signed [CW-1:0] char_x;
    logic signed [CW-1:0] char_y;
    logic signed [CW-1:0] char_z;
    logic signed [CW-1:0] cam_x;
    logic signed [CW-1:0] cam_y;
    logic signed [CW-1:0] cam_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 hit_found;
  } out_t;

  typedef struct packed {
    logic                 zero;
    logic [2:0]           dneg;
    logic [2:0][DW-1:0]   a;
    logic                 sh_right;
    logic [SHW-1:0]       sh_amt;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cz;
    logic [EW-1:0]        e;
    logic [2:0][CW-1:0]   cam;
  } fr_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [FQ_CW-1:0] cnt;
  } fq_st_t;

endpackage

[rtl/core/cbp_if.sv]
// ----------------------------------------------------------------------------
// cbp_if
// valid/ready channels for query items and result items
// ----------------------------------------------------------------------------
interface cbp_in_if import cbp_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbp_out_if import cbp_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/cbp_front.sv]
// ----------------------------------------------------------------------------
// cbp_front
// clamps the character onto the cube, forms the offset and its normalize shift
// ----------------------------------------------------------------------------
module cbp_front import cbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  cbp_in_if.sink   req_i,
  output logic     fr_valid_o,
  output fr_t      fr_data_o,
  input  logic     fr_ready_i
);

  fr_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic [DW-1:0]        m_d, m_q;
  logic [2:0]           vld_q;
  logic                 adv;
  logic signed [DW-1:0] cxw, czw, ew;
  logic signed [DW-1:0] ch [3];
  logic signed [DW-1:0] lo [3];
  logic signed [DW-1:0] hi [3];
  logic signed [DW-1:0] nr [3];
  logic [SHW-1:0]       pos;

  assign adv         = !vld_q[2] || fr_ready_i;
  assign req_i.ready = adv;
  assign fr_valid_o  = vld_q[2];
  assign fr_data_o   = s3_q;

  // clamp and offset
  always_comb begin
    cxw   = DW'(req_i.data.box_corner_x);
    czw   = DW'(req_i.data.box_corner_z);
    ew    = DW'(req_i.data.edge_size);
    ch[0] = DW'(req_i.data.char_x);
    ch[1] = DW'(req_i.data.char_y);
    ch[2] = DW'(req_i.data.char_z);
    lo[0] = cxw;
    hi[0] = cxw + ew;
    lo[1] = '0;
    hi[1] = ew;
    lo[2] = czw - ew;
    hi[2] = czw;
    s1_d        = '0;
    s1_d.cx     = req_i.data.box_corner_x;
    s1_d.cz     = req_i.data.box_corner_z;
    s1_d.e      = req_i.data.edge_size;
    s1_d.cam[0] = req_i.data.cam_x;
    s1_d.cam[1] = req_i.data.cam_y;
    s1_d.cam[2] = req_i.data.cam_z;
    for (int i = 0; i < 3; i++) begin
      if (ch[i] < lo[i]) begin
        nr[i] = lo[i];
      end else if (ch[i] > hi[i]) begin
        nr[i] = hi[i];
      end else begin
        nr[i] = ch[i];
      end
      s1_d.a[i] = ch[i] - nr[i];
    end
  end

  // magnitudes and largest
  always_comb begin
    s2_d = s1_q;
    m_d  = '0;
    for (int i = 0; i < 3; i++) begin
      s2_d.dneg[i] = s1_q.a[i][DW-1];
      s2_d.a[i]    = s1_q.a[i][DW-1] ? -s1_q.a[i] : s1_q.a[i];
      if (s2_d.a[i] > m_d) begin
        m_d = s2_d.a[i];
      end
    end
  end

  // leading one and shift
  always_comb begin
    s3_d = s2_q;
    pos  = '0;
    for (int b = 0; b < DW; b++) begin
      if (m_q[b]) begin
        pos = SHW'(b);
      end
    end
    s3_d.zero = (m_q == '0);
    if (pos > SHW'(NW - 1)) begin
      s3_d.sh_right = 1'b1;
      s3_d.sh_amt   = pos - SHW'(NW - 1);
    end else begin
      s3_d.sh_right = 1'b0;
      s3_d.sh_amt   = SHW'(NW - 1) - pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      m_q  <= m_d;
      s3_q <= s3_d;
    end
  end

endmodule

[rtl/core/cbp_fifo.sv]
// ----------------------------------------------------------------------------
// cbp_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module cbp_fifo import cbp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  fr_t    data_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output fr_t    data_o,
  output fq_st_t stat_o
);

  fr_t              mem_q [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_q, rd_q;
  logic [FQ_CW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == FQ_CW'(FQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.cnt   = cnt_q;
  assign ready_o      = !stat_o.full;
  assign valid_o      = !stat_o.empty;
  assign data_o       = mem_q[rd_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/core/cbp_back.sv]
// ----------------------------------------------------------------------------
// cbp_back
// root, direction divide, plane divides, nearest pick and push-out
// ----------------------------------------------------------------------------
module cbp_back import cbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fq_valid_i,
  input  fr_t       fq_data_i,
  output logic      fq_pop_o,
  input  logic [EW-1:0] push_margin_i,
  cbp_out_if.source rsp_o
);

  localparam int RTN    = RW / 2;
  localparam int ST_SH  = 1;
  localparam int ST_SQ  = 2;
  localparam int ST_SUM = 3;
  localparam int ST_RT0 = 4;
  localparam int ST_VI  = ST_RT0 + RTN;
  localparam int ST_VD0 = ST_VI + 1;
  localparam int ST_PI  = ST_VD0 + QVW;
  localparam int ST_PD0 = ST_PI + 1;
  localparam int ST_M1  = ST_PD0 + PNW;
  localparam int ST_M2  = ST_M1 + 1;
  localparam int ST_T   = ST_M2 + 1;
  localparam int NST    = ST_T + 1;

  localparam logic signed [AW-1:0] CMAX = $signed({{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [AW-1:0] CMIN = $signed({{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}});

  typedef struct packed {
    logic                  zero;
    logic [2:0]            dneg;
    logic [2:0][NW-1:0]    an;
    logic [2:0][2*NW-1:0]  sq;
    logic [RW-1:0]         sx;
    logic [SRW-1:0]        srem;
    logic [LW-1:0]         root;
    logic [2:0][VRW-1:0]   vrem;
    logic [2:0][QVW-1:0]   vnx;
    logic [2:0][QVW-1:0]   vq;
    logic [3:0]            nneg;
    logic [3:0]            nnz;
    logic [3:0]            pok;
    logic [3:0][PNW-1:0]   pnx;
    logic [3:0][PRW-1:0]   prem;
    logic [3:0][PNW-1:0]   pq;
    logic                  f01;
    logic                  f23;
    logic [PNW-1:0]        m01;
    logic [PNW-1:0]        m23;
    logic                  found;
    logic [PNW-1:0]        best;
    logic [TW-1:0]         t;
    logic [2:0][MW-1:0]    prod;
    logic [2:0][CW-1:0]    cam;
  } ctx_t;

  ctx_t                 ctx_q [1:NST];
  ctx_t                 ctx_d [1:NST];
  logic [NST:1]         vld_q;
  out_t                 out_d, out_q;
  logic                 out_vld_q;
  logic                 adv;
  logic [DW-1:0]        cxw, czw, ew, cam0w, cam2w;
  logic [3:0][DW-1:0]   num;
  logic [2:0][MW-1:0]   pc;
  logic signed [AW-1:0] ax [3];
  logic [2:0][CW-1:0]   res;
  logic                 hit;

  assign adv         = !out_vld_q || rsp_o.ready;
  assign fq_pop_o    = adv && fq_valid_i;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // normalize and plane numerators
  always_comb begin
    cxw    = DW'(fq_data_i.cx);
    czw    = DW'(fq_data_i.cz);
    ew     = DW'(fq_data_i.e);
    cam0w  = DW'($signed(fq_data_i.cam[0]));
    cam2w  = DW'($signed(fq_data_i.cam[2]));
    num[0] = czw - cam2w;
    num[1] = cxw - cam0w;
    num[2] = czw - ew - cam2w;
    num[3] = cxw + ew - cam0w;
    ctx_d[ST_SH]      = '0;
    ctx_d[ST_SH].zero = fq_data_i.zero;
    ctx_d[ST_SH].dneg = fq_data_i.dneg;
    ctx_d[ST_SH].cam  = fq_data_i.cam;
    for (int i = 0; i < 3; i++) begin
      if (fq_data_i.sh_right) begin
        ctx_d[ST_SH].an[i] = NW'(fq_data_i.a[i] >> fq_data_i.sh_amt);
      end else begin
        ctx_d[ST_SH].an[i] = NW'(fq_data_i.a[i] << fq_data_i.sh_amt);
      end
    end
    for (int j = 0; j < 4; j++) begin
      ctx_d[ST_SH].nneg[j] = num[j][DW-1];
      ctx_d[ST_SH].nnz[j]  = |num[j];
      ctx_d[ST_SH].pnx[j]  = {(num[j][DW-1] ? -num[j] : num[j]), {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = ST_SQ; k <= NST; k++) begin : g_st
    if (k == ST_SQ) begin : g_sq
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int i = 0; i < 3; i++) begin
          ctx_d[k].sq[i] = ctx_q[k-1].an[i] * ctx_q[k-1].an[i];
        end
      end
    end else if (k == ST_SUM) begin : g_sum
      always_comb begin
        ctx_d[k]      = ctx_q[k-1];
        ctx_d[k].sx   = RW'(ctx_q[k-1].sq[0]) + RW'(ctx_q[k-1].sq[1])
                      + RW'(ctx_q[k-1].sq[2]);
        ctx_d[k].srem = '0;
        ctx_d[k].root = '0;
      end
    end else if (k < ST_VI) begin : g_rt
      logic [SRW-1:0] r2, tr;
      assign r2 = {ctx_q[k-1].srem[SRW-3:0], ctx_q[k-1].sx[RW-1 -: 2]};
      assign tr = SRW'({ctx_q[k-1].root, 2'b01});
      always_comb begin
        ctx_d[k]    = ctx_q[k-1];
        ctx_d[k].sx = ctx_q[k-1].sx << 2;
        if (r2 >= tr) begin
          ctx_d[k].srem = r2 - tr;
          ctx_d[k].root = {ctx_q[k-1].root[LW-2:0], 1'b1};
        end else begin
          ctx_d[k].srem = r2;
          ctx_d[k].root = {ctx_q[k-1].root[LW-2:0], 1'b0};
        end
      end
    end else if (k == ST_VI) begin : g_vi
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int i = 0; i < 3; i++) begin
          ctx_d[k].vrem[i] = VRW'(ctx_q[k-1].an[i] >> 1);
          ctx_d[k].vnx[i]  = {ctx_q[k-1].an[i][0], {FRAC_BITS{1'b0}}};
          ctx_d[k].vq[i]   = '0;
        end
      end
    end else if (k < ST_PI) begin : g_vd
      logic [2:0][VRW-1:0] r2;
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int i = 0; i < 3; i++) begin
          r2[i] = {ctx_q[k-1].vrem[i][VRW-2:0], ctx_q[k-1].vnx[i][QVW-1]};
          ctx_d[k].vnx[i] = ctx_q[k-1].vnx[i] << 1;
          if (r2[i] >= VRW'(ctx_q[k-1].root)) begin
            ctx_d[k].vrem[i] = r2[i] - VRW'(ctx_q[k-1].root);
            ctx_d[k].vq[i]   = {ctx_q[k-1].vq[i][QVW-2:0], 1'b1};
          end else begin
            ctx_d[k].vrem[i] = r2[i];
            ctx_d[k].vq[i]   = {ctx_q[k-1].vq[i][QVW-2:0], 1'b0};
          end
        end
      end
    end else if (k == ST_PI) begin : g_pi
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int j = 0; j < 4; j++) begin
          ctx_d[k].pok[j]  = (|ctx_q[k-1].vq[j % 2 == 0 ? 2 : 0])
                           && (!ctx_q[k-1].nnz[j]
                               || ctx_q[k-1].nneg[j] == ctx_q[k-1].dneg[j % 2 == 0 ? 2 : 0]);
          ctx_d[k].prem[j] = '0;
          ctx_d[k].pq[j]   = '0;
        end
      end
    end else if (k < ST_M1) begin : g_pd
      logic [3:0][PRW-1:0] r2;
      logic [3:0][PRW-1:0] dv;
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int j = 0; j < 4; j++) begin
          dv[j] = PRW'(ctx_q[k-1].vq[j % 2 == 0 ? 2 : 0]);
          r2[j] = {ctx_q[k-1].prem[j][PRW-2:0], ctx_q[k-1].pnx[j][PNW-1]};
          ctx_d[k].pnx[j] = ctx_q[k-1].pnx[j] << 1;
          if (r2[j] >= dv[j]) begin
            ctx_d[k].prem[j] = r2[j] - dv[j];
            ctx_d[k].pq[j]   = {ctx_q[k-1].pq[j][PNW-2:0], 1'b1};
          end else begin
            ctx_d[k].prem[j] = r2[j];
            ctx_d[k].pq[j]   = {ctx_q[k-1].pq[j][PNW-2:0], 1'b0};
          end
        end
      end
    end else if (k == ST_M1) begin : g_m1
      always_comb begin
        ctx_d[k]     = ctx_q[k-1];
        ctx_d[k].f01 = ctx_q[k-1].pok[0] || ctx_q[k-1].pok[1];
        ctx_d[k].f23 = ctx_q[k-1].pok[2] || ctx_q[k-1].pok[3];
        ctx_d[k].m01 = (ctx_q[k-1].pok[0] && (!ctx_q[k-1].pok[1]
                       || ctx_q[k-1].pq[0] <= ctx_q[k-1].pq[1]))
                       ? ctx_q[k-1].pq[0] : ctx_q[k-1].pq[1];
        ctx_d[k].m23 = (ctx_q[k-1].pok[2] && (!ctx_q[k-1].pok[3]
                       || ctx_q[k-1].pq[2] <= ctx_q[k-1].pq[3]))
                       ? ctx_q[k-1].pq[2] : ctx_q[k-1].pq[3];
      end
    end else if (k == ST_M2) begin : g_m2
      always_comb begin
        ctx_d[k]       = ctx_q[k-1];
        ctx_d[k].found = ctx_q[k-1].f01 || ctx_q[k-1].f23;
        ctx_d[k].best  = (ctx_q[k-1].f01 && (!ctx_q[k-1].f23
                         || ctx_q[k-1].m01 <= ctx_q[k-1].m23))
                         ? ctx_q[k-1].m01 : ctx_q[k-1].m23;
      end
    end else if (k == ST_T) begin : g_t
      always_comb begin
        ctx_d[k]   = ctx_q[k-1];
        ctx_d[k].t = TW'(ctx_q[k-1].best) + TW'(push_margin_i);
      end
    end else begin : g_mul
      always_comb begin
        ctx_d[k] = ctx_q[k-1];
        for (int i = 0; i < 3; i++) begin
          ctx_d[k].prod[i] = MW'(ctx_q[k-1].t) * MW'(ctx_q[k-1].vq[i]);
        end
      end
    end
  end

  // saturate, add to camera, clamp
  always_comb begin
    hit = ctx_q[NST].found && !ctx_q[NST].zero;
    for (int i = 0; i < 3; i++) begin
      pc[i] = (ctx_q[NST].prod[i] > SAT_LIM) ? SAT_LIM : ctx_q[NST].prod[i];
      ax[i] = AW'($signed(ctx_q[NST].cam[i]));
      if (ctx_q[NST].dneg[i]) begin
        ax[i] = ax[i] - AW'(pc[i] >> FRAC_BITS);
      end else begin
        ax[i] = ax[i] + AW'(pc[i] >> FRAC_BITS);
      end
      if (ax[i] > CMAX) begin
        ax[i] = CMAX;
      end else if (ax[i] < CMIN) begin
        ax[i] = CMIN;
      end
      res[i] = hit ? ax[i][CW-1:0] : '0;
    end
    out_d.out_x     = res[0];
    out_d.out_y     = res[1];
    out_d.out_z     = res[2];
    out_d.hit_found = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NST-1:1], fq_valid_i};
      out_vld_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 1; k <= NST; k++) begin
        ctx_q[k] <= ctx_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule

[rtl/core/camera_box_pushout_point_top.sv]
// ----------------------------------------------------------------------------
// camera_box_pushout_point_top
// pushes a camera point out past the nearest side plane of a cube
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_i     in   valid/ready        cube corner, edge, character, camera
//  rsp_o     out  valid/ready        pushed camera, hit flag
//  cfg       in   cfg_we_i           push margin
//
//  one item per cycle sustained while rsp_o is ready; at 16 fractional bits the
//  back pipe holds a 32-step square root and a (34 + frac)-step plane divide
//  reset clears all valid state; push margin returns to 0.2
//  a stalled result holds the back pipe; the front keeps taking items
//  until the four-entry queue fills
// ----------------------------------------------------------------------------
module camera_box_pushout_point_top import cbp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [EW-1:0] cfg_wdata_i,
  cbp_in_if.sink        req_i,
  cbp_out_if.source     rsp_o
);

  logic [EW-1:0] margin_q;
  logic          fr_valid, fr_ready;
  fr_t           fr_data;
  logic          fq_valid, bk_pop;
  fr_t           fq_data;
  fq_st_t        fq_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      margin_q <= cfg_wdata_i;
    end
  end

  cbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .fr_valid_o (fr_valid),
    .fr_data_o  (fr_data),
    .fr_ready_i (fr_ready)
  );

  cbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_data),
    .ready_o (fr_ready),
    .pop_i   (bk_pop),
    .valid_o (fq_valid),
    .data_o  (fq_data),
    .stat_o  (fq_stat)
  );

  cbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fq_valid_i    (fq_valid),
    .fq_data_i     (fq_data),
    .fq_pop_o      (bk_pop),
    .push_margin_i (margin_q),
    .rsp_o         (rsp_o)
  );

  a_fq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_stat.cnt <= FQ_CW'(FQ_DEPTH))
    else $error("queue count beyond depth");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> !fq_stat.empty)
    else $error("back popped an empty queue");

  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.data.hit_found |->
      rsp_o.data.out_x == '0 && rsp_o.data.out_y == '0 && rsp_o.data.out_z == '0)
    else $error("result without hit is not zero");

endmodule
